>>> design/uvsd_pkg.sv
package uvsd_pkg;

	// Field widths of the byte stream and of the decoded results.
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned VALUE_W  = 63;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned STATUS_W = 2;

	// Each encoded byte carries one group of seven value bits.
	localparam int unsigned GROUP_BITS = 7;
	localparam int unsigned NUM_GROUPS = VALUE_W / GROUP_BITS;

	// Position of the continuation flag within a byte.
	localparam int unsigned CONT_BIT = 7;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TRUNCATED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NONMINIMAL = 2'd3;

	// One word of the input stream.
	typedef struct packed {
		logic              byte_present;
		logic [DATA_W-1:0] data_byte;
		logic              end_of_buffer;
	} item_t;

	// Outcome of one decode step; emit marks that a result word is produced.
	typedef struct packed {
		logic                emit;
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  varint_value;
		logic [POS_W-1:0]    bytes_read;
	} step_t;

endpackage

>>> design/uvsd_in_if.sv
interface uvsd_in_if;

	logic                        valid;
	logic                        ready;
	logic                        byte_present;
	logic [uvsd_pkg::DATA_W-1:0] data_byte;
	logic                        end_of_buffer;

	modport source (output valid, output byte_present, output data_byte,
		output end_of_buffer, input ready);
	modport sink (input valid, input byte_present, input data_byte,
		input end_of_buffer, output ready);

endinterface

>>> design/uvsd_out_if.sv
interface uvsd_out_if;

	logic                          valid;
	logic                          ready;
	logic [uvsd_pkg::STATUS_W-1:0] status;
	logic [uvsd_pkg::VALUE_W-1:0]  varint_value;
	logic [uvsd_pkg::POS_W-1:0]    bytes_read;

	modport source (output valid, output status, output varint_value,
		output bytes_read, input ready);
	modport sink (input valid, input status, input varint_value,
		input bytes_read, output ready);

endinterface

>>> design/uvsd_core.sv
module uvsd_core #(
	parameter int unsigned MAX_BYTES = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  uvsd_pkg::item_t item,
	output uvsd_pkg::step_t res
);

	localparam logic [uvsd_pkg::POS_W-1:0] MAX_POS  = uvsd_pkg::POS_W'(MAX_BYTES);
	localparam logic [uvsd_pkg::POS_W-1:0] LAST_POS = uvsd_pkg::POS_W'(MAX_BYTES - 1);

	logic [uvsd_pkg::VALUE_W-1:0] acc_q;
	logic [uvsd_pkg::POS_W-1:0]   pos_q;
	logic [uvsd_pkg::VALUE_W-1:0] acc_d;
	logic [uvsd_pkg::POS_W-1:0]   pos_d;
	logic [uvsd_pkg::VALUE_W-1:0] group_bits;
	logic [uvsd_pkg::VALUE_W-1:0] acc_or;
	logic                         cont;

	// Place the low seven bits of the byte into the group selected by the position.
	for (genvar g = 0; g < uvsd_pkg::NUM_GROUPS; g++) begin : g_group
		assign group_bits[g*uvsd_pkg::GROUP_BITS +: uvsd_pkg::GROUP_BITS] =
			(pos_q == uvsd_pkg::POS_W'(g)) ?
			item.data_byte[uvsd_pkg::GROUP_BITS-1:0] : '0;
	end

	assign acc_or = acc_q | group_bits;
	assign cont   = item.data_byte[uvsd_pkg::CONT_BIT];

	// Decode one word against the current accumulator and position.
	always_comb begin
		res   = '0;
		acc_d = acc_q;
		pos_d = pos_q;
		if (!item.byte_present) begin
			if (item.end_of_buffer) begin
				res.emit   = 1'b1;
				res.status = uvsd_pkg::ST_TRUNCATED;
			end
		end else if (pos_q >= MAX_POS || (pos_q == LAST_POS && cont)) begin
			res.emit   = 1'b1;
			res.status = uvsd_pkg::ST_OVERFLOW;
		end else if (!cont) begin
			res.emit = 1'b1;
			if (pos_q != '0 && item.data_byte == '0) begin
				res.status = uvsd_pkg::ST_NONMINIMAL;
			end else begin
				res.status       = uvsd_pkg::ST_OK;
				res.varint_value = acc_or;
				res.bytes_read   = pos_q + uvsd_pkg::POS_W'(1);
			end
		end else begin
			acc_d = acc_or;
			pos_d = pos_q + uvsd_pkg::POS_W'(1);
			if (item.end_of_buffer) begin
				res.emit   = 1'b1;
				res.status = uvsd_pkg::ST_TRUNCATED;
			end
		end
		// Every result starts a fresh varint.
		if (res.emit) begin
			acc_d = '0;
			pos_d = '0;
		end
	end

	// Decoder state advances only when the word leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
		end else if (step) begin
			acc_q <= acc_d;
			pos_q <= pos_d;
		end
	end

endmodule

>>> design/unsigned_varint_stream_decoder_unit.sv
// Unsigned LEB128 varint decoder. One encoded byte enters per word on the stream
// port and the block sustains one word per clock cycle unless a held result word
// stalls it; a result word for the byte that completes or fails the varint passes
// the input register, the combinational group insert into the 63-bit accumulator
// and the result register to the result port. Status is ok (with the value and the
// byte count), truncated (end of buffer before a terminal byte, including a bare
// end marker), overflow (continuation bit on byte MAX_BYTES) or non-minimal (zero
// terminal byte after the first). Decoding restarts at the byte after any result.
module unsigned_varint_stream_decoder_unit #(
	parameter int unsigned MAX_BYTES = 9
) (
	input logic       clk,
	input logic       arst_n,
	uvsd_in_if.sink   stream,
	uvsd_out_if.source result
);

	logic            valid_s1;
	uvsd_pkg::item_t item_s1;
	logic            res_valid_q;
	uvsd_pkg::step_t res_q;
	uvsd_pkg::step_t step_res;
	logic            advance;
	logic            take;

	// A word leaves the input stage if it makes no result or the result slot frees.
	assign advance      = !step_res.emit || !res_valid_q || result.ready;
	assign stream.ready = !valid_s1 || advance;
	assign take         = stream.valid && stream.ready;

	uvsd_core #(
		.MAX_BYTES(MAX_BYTES)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (valid_s1 && advance),
		.item  (item_s1),
		.res   (step_res)
	);

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.byte_present  <= stream.byte_present;
			item_s1.data_byte     <= stream.data_byte;
			item_s1.end_of_buffer <= stream.end_of_buffer;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (valid_s1 && advance && step_res.emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && step_res.emit) begin
			res_q <= step_res;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.status       = res_q.status;
	assign result.varint_value = res_q.varint_value;
	assign result.bytes_read   = res_q.bytes_read;

endmodule

>>> verif/tb_unsigned_varint_stream_decoder_unit.sv
`timescale 1ns / 100ps

module tb_unsigned_varint_stream_decoder_unit;

	localparam int unsigned MAX_BYTES     = 9;
	localparam int          RANDOM_PHASES = 4;
	localparam int          PHASE_WORDS   = 420;
	localparam int          HOLD_CYCLES   = 150;
	localparam int          STALL_LIMIT   = 2000;
	localparam int          DRAIN_CYCLES  = 10;
	localparam int          REPORT_MAX    = 10;

	// One word offered on the byte stream, with a hand-written expectation when typed is set.
	typedef struct {
		uvsd_pkg::item_t word;
		bit              typed;
		uvsd_pkg::step_t want;
	} stream_row_t;

	logic clk;
	logic arst_n;

	uvsd_in_if  stream_ch ();
	uvsd_out_if result_ch ();

	unsigned_varint_stream_decoder_unit #(
		.MAX_BYTES(MAX_BYTES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	// Decoder state mirrored by the predictor.
	logic [uvsd_pkg::VALUE_W-1:0] dec_acc;
	logic [uvsd_pkg::POS_W-1:0]   dec_pos;

	stream_row_t     directed_rows[$];
	stream_row_t     offered_words[$];
	uvsd_pkg::step_t pending_results[$];

	int tx_idle_pct;
	int rx_stall_pct;
	bit hold_off_req;
	int words_sent;
	int fail_count;
	int idle_cycles;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Predicts the outcome of one accepted word and advances the mirrored decoder state.
	function automatic uvsd_pkg::step_t decode_next_byte(input uvsd_pkg::item_t w);
		uvsd_pkg::step_t              r;
		logic [uvsd_pkg::VALUE_W-1:0] grp;
		r = '0;
		if (!w.byte_present) begin
			if (w.end_of_buffer) begin
				r.emit   = 1'b1;
				r.status = uvsd_pkg::ST_TRUNCATED;
			end
		end else if (dec_pos >= MAX_BYTES ||
				(dec_pos == MAX_BYTES - 1 && w.data_byte[uvsd_pkg::CONT_BIT])) begin
			r.emit   = 1'b1;
			r.status = uvsd_pkg::ST_OVERFLOW;
		end else begin
			grp     = uvsd_pkg::VALUE_W'(w.data_byte[uvsd_pkg::GROUP_BITS-1:0]);
			dec_acc = dec_acc | (grp << (uvsd_pkg::GROUP_BITS * dec_pos));
			if (!w.data_byte[uvsd_pkg::CONT_BIT]) begin
				r.emit = 1'b1;
				if (dec_pos != 0 && w.data_byte == '0) begin
					r.status = uvsd_pkg::ST_NONMINIMAL;
				end else begin
					r.status       = uvsd_pkg::ST_OK;
					r.varint_value = dec_acc;
					r.bytes_read   = dec_pos + 1'b1;
				end
			end else begin
				dec_pos = dec_pos + 1'b1;
				if (w.end_of_buffer) begin
					r.emit   = 1'b1;
					r.status = uvsd_pkg::ST_TRUNCATED;
				end
			end
		end
		if (r.emit) begin
			dec_acc = '0;
			dec_pos = '0;
		end
		return r;
	endfunction

	task automatic report_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX) begin
			$display("%t: %s", $realtime, msg);
		end
	endtask

	task automatic add_row(input logic present, input logic [uvsd_pkg::DATA_W-1:0] data,
			input logic eob, input bit typed, input logic emit,
			input logic [uvsd_pkg::STATUS_W-1:0] status,
			input logic [uvsd_pkg::VALUE_W-1:0] value,
			input logic [uvsd_pkg::POS_W-1:0] count);
		stream_row_t row;
		row.word              = {present, data, eob};
		row.typed             = typed;
		row.want.emit         = emit;
		row.want.status       = status;
		row.want.varint_value = value;
		row.want.bytes_read   = count;
		directed_rows.push_back(row);
	endtask

	// Offers one word after an optional idle stretch and waits until it is taken.
	task automatic send_word(input stream_row_t row);
		if ($urandom_range(99) < tx_idle_pct) begin
			stream_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		offered_words.push_back(row);
		stream_ch.valid         <= 1'b1;
		stream_ch.byte_present  <= row.word.byte_present;
		stream_ch.data_byte     <= row.word.data_byte;
		stream_ch.end_of_buffer <= row.word.end_of_buffer;
		do @(posedge clk); while (stream_ch.ready !== 1'b1);
		if (row.word.byte_present || row.word.end_of_buffer) begin
			words_sent++;
		end
	endtask

	task automatic send_checked(input uvsd_pkg::item_t w);
		stream_row_t row;
		row.word  = w;
		row.typed = 1'b0;
		row.want  = '0;
		send_word(row);
	endtask

	// Sends one varint, mostly well formed, sometimes broken, sometimes plain noise.
	task automatic send_random_varint();
		uvsd_pkg::item_t w;
		int              kind;
		int              pick;
		int              nbytes;
		bit              last_cont;
		bit              zero_last;
		bit              eob;
		bit              marker;
		kind      = $urandom_range(99);
		pick      = $urandom_range(99);
		nbytes    = (pick < 50) ? $urandom_range(1, 2) :
			(pick < 80) ? $urandom_range(3, 5) : $urandom_range(6, MAX_BYTES);
		last_cont = 1'b0;
		zero_last = 1'b0;
		eob       = ($urandom_range(3) == 0);
		marker    = 1'b0;
		if (kind >= 94) begin
			// Noise: any combination of the three fields.
			w.byte_present  = 1'($urandom_range(1));
			w.data_byte     = 8'($urandom_range(255));
			w.end_of_buffer = 1'($urandom_range(1));
			send_checked(w);
		end else begin
			if (kind >= 65 && kind < 73) begin
				// Zero terminal byte after the first byte.
				if (nbytes < 2) nbytes = 2;
				zero_last = 1'b1;
			end else if (kind >= 73 && kind < 80) begin
				// Continuation bit still set on the last allowed byte.
				nbytes    = MAX_BYTES;
				last_cont = 1'b1;
			end else if (kind >= 80 && kind < 88) begin
				// Buffer ends on a continuation byte.
				if (nbytes > MAX_BYTES - 1) nbytes = MAX_BYTES - 1;
				last_cont = 1'b1;
				eob       = 1'b1;
			end else if (kind >= 88) begin
				// Bare end marker before the terminal byte, possibly on an empty buffer.
				if (nbytes > MAX_BYTES - 1) nbytes = MAX_BYTES - 1;
				nbytes    = nbytes - 1;
				last_cont = 1'b1;
				eob       = 1'b0;
				marker    = 1'b1;
			end
			for (int i = 0; i < nbytes; i++) begin
				if ($urandom_range(99) < 4) begin
					w = {1'b0, 8'($urandom_range(255)), 1'b0};
					send_checked(w);
				end
				w.byte_present                  = 1'b1;
				w.data_byte                     = 8'($urandom_range(255));
				w.data_byte[uvsd_pkg::CONT_BIT] = (i < nbytes - 1) || last_cont;
				if (i == nbytes - 1 && zero_last) w.data_byte = '0;
				w.end_of_buffer                 = (i == nbytes - 1) ? eob : 1'b0;
				send_checked(w);
			end
			if (marker) begin
				w = {1'b0, 8'($urandom_range(255)), 1'b1};
				send_checked(w);
			end
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			result_ch.ready <= arst_n && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Check result words against the oldest expectation, then predict for the accepted word.
	always @(posedge clk) begin
		stream_row_t     nt;
		uvsd_pkg::step_t pred;
		uvsd_pkg::step_t want;
		uvsd_pkg::item_t w;
		if (arst_n) begin
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_failure($sformatf("unexpected result: status %0d value %0h bytes %0d",
						result_ch.status, result_ch.varint_value, result_ch.bytes_read));
				end else begin
					want = pending_results.pop_front();
					if (result_ch.status !== want.status ||
							result_ch.varint_value !== want.varint_value ||
							result_ch.bytes_read !== want.bytes_read) begin
						report_failure($sformatf({"result mismatch: expected status %0d value %0h ",
							"bytes %0d, got status %0d value %0h bytes %0d"},
							want.status, want.varint_value, want.bytes_read,
							result_ch.status, result_ch.varint_value, result_ch.bytes_read));
					end
				end
			end
			if (stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1) begin
				w    = {stream_ch.byte_present, stream_ch.data_byte, stream_ch.end_of_buffer};
				nt   = offered_words.pop_front();
				pred = decode_next_byte(w);
				if (nt.typed) pred = nt.want;
				if (pred.emit) pending_results.push_back(pred);
			end
		end
	end

	// Watchdog on cycles without any accepted word or result.
	always @(posedge clk) begin
		if (!arst_n || (stream_ch.valid && stream_ch.ready) ||
				(result_ch.valid && result_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Main sequence: reset, directed table, then random phases with different idling.
	initial begin
		int tx_pct[RANDOM_PHASES];
		int rx_pct[RANDOM_PHASES];
		int target;
		tx_pct = '{0, 52, 0, 8};
		rx_pct = '{0, 0, 52, 8};
		arst_n                  = 1'b0;
		stream_ch.valid         = 1'b0;
		stream_ch.byte_present  = 1'b0;
		stream_ch.data_byte     = '0;
		stream_ch.end_of_buffer = 1'b0;
		dec_acc                 = '0;
		dec_pos                 = '0;
		tx_idle_pct             = 0;
		rx_stall_pct            = 0;
		hold_off_req            = 1'b0;
		words_sent              = 0;
		fail_count              = 0;
		idle_cycles             = 0;

		// Empty buffer right after reset, an ignored word, single-byte extremes.
		add_row(1'b0, 8'h00, 1'b1, 1'b1, 1'b1, uvsd_pkg::ST_TRUNCATED, '0, '0);
		add_row(1'b0, 8'hFF, 1'b0, 1'b1, 1'b0, uvsd_pkg::ST_OK, '0, '0);
		add_row(1'b1, 8'h00, 1'b0, 1'b1, 1'b1, uvsd_pkg::ST_OK, '0, 4'd1);
		add_row(1'b1, 8'h7F, 1'b1, 1'b1, 1'b1, uvsd_pkg::ST_OK, 63'd127, 4'd1);
		// Zero terminal byte after a continuation byte.
		add_row(1'b1, 8'h80, 1'b0, 1'b0, 1'b0, uvsd_pkg::ST_OK, '0, '0);
		add_row(1'b1, 8'h00, 1'b0, 1'b1, 1'b1, uvsd_pkg::ST_NONMINIMAL, '0, '0);
		// Buffer ends on a continuation byte.
		add_row(1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, uvsd_pkg::ST_TRUNCATED, '0, '0);
		// Ignored word inside a varint, then a bare end marker.
		add_row(1'b1, 8'hAA, 1'b0, 1'b0, 1'b0, uvsd_pkg::ST_OK, '0, '0);
		add_row(1'b0, 8'h55, 1'b0, 1'b0, 1'b0, uvsd_pkg::ST_OK, '0, '0);
		add_row(1'b0, 8'h00, 1'b1, 1'b1, 1'b1, uvsd_pkg::ST_TRUNCATED, '0, '0);
		// Largest value in the longest encoding.
		for (int i = 0; i < MAX_BYTES - 1; i++) begin
			add_row(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, uvsd_pkg::ST_OK, '0, '0);
		end
		add_row(1'b1, 8'h7F, 1'b0, 1'b1, 1'b1, uvsd_pkg::ST_OK, 63'h7FFF_FFFF_FFFF_FFFF,
			4'(MAX_BYTES));
		// Continuation bit on the last allowed byte.
		for (int i = 0; i < MAX_BYTES - 1; i++) begin
			add_row(1'b1, 8'h80, 1'b0, 1'b0, 1'b0, uvsd_pkg::ST_OK, '0, '0);
		end
		add_row(1'b1, 8'h81, 1'b0, 1'b1, 1'b1, uvsd_pkg::ST_OVERFLOW, '0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_word(directed_rows[i]);
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			tx_idle_pct  = tx_pct[phase];
			rx_stall_pct = rx_pct[phase];
			// The first phase opens with a long result hold-off so the input backs up.
			if (phase == 0) hold_off_req = 1'b1;
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				send_random_varint();
			end
		end

		stream_ch.valid <= 1'b0;
		rx_stall_pct = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
